[hw/rtl/spqa_pkg.sv]
// ----------------------------------------------------------------------------
// spqa_pkg
// Types and codes used by the aging priority queue controller and datapath.
// ----------------------------------------------------------------------------
package spqa_pkg;

  localparam int unsigned PrioW = 8;
  localparam int unsigned PatW  = 16;
  localparam int unsigned PayW  = 32;
  localparam int unsigned TagW  = 8;
  localparam int unsigned AmtW  = 15;
  localparam int unsigned OccW  = 5;

  typedef enum logic [1:0] {
    REQ_ENQ    = 2'd0,
    REQ_DEQ    = 2'd1,
    REQ_REDUCE = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL_ERR  = 2'd1,
    ST_EMPTY_ERR = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_DONE
  } fsm_e;

  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [PatW-1:0]  patience;
    logic [PayW-1:0]  payload;
    logic [TagW-1:0]  tag;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch request fields
    logic exec;     // perform the latched request on all cells
  } cmd_t;

  // datapath status, checked by the core's assertion
  typedef struct packed {
    logic empty;
    logic full;
  } stat_t;

endpackage

[hw/rtl/spqa_ctrl.sv]
// ----------------------------------------------------------------------------
// spqa_ctrl
// Request sequencer: capture a beat, execute it, hold the result beat.
// ----------------------------------------------------------------------------
module spqa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output spqa_pkg::cmd_t cmd_o
);
  import spqa_pkg::*;

  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: if (in_valid_i) state_d = FSM_EXEC;
      FSM_EXEC: state_d = FSM_DONE;
      FSM_DONE: begin
        // take the next beat while the result leaves
        if (out_ready_i) state_d = in_valid_i ? FSM_EXEC : FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      FSM_IDLE: in_ready_o = 1'b1;
      FSM_EXEC: cmd_o.exec = 1'b1;
      FSM_DONE: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
      end
      default: ;
    endcase
    cmd_o.capture = in_ready_o & in_valid_i;
  end

endmodule

[hw/rtl/spqa_dp.sv]
// ----------------------------------------------------------------------------
// spqa_dp
// Sorted shift-register cells with a parallel insert, shift and age step.
// ----------------------------------------------------------------------------
module spqa_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spqa_pkg::cmd_t                cmd_i,
  output spqa_pkg::stat_t               stat_o,
  input  logic [1:0]                    req_type_i,
  input  logic [spqa_pkg::PrioW-1:0]    new_prio_i,
  input  logic signed [spqa_pkg::PatW-1:0] new_patience_i,
  input  logic [spqa_pkg::PayW-1:0]     new_payload_i,
  input  logic [spqa_pkg::TagW-1:0]     new_tag_i,
  input  logic [spqa_pkg::AmtW-1:0]     amount_i,
  output logic [spqa_pkg::PrioW-1:0]    out_prio_o,
  output logic signed [spqa_pkg::PatW-1:0] out_patience_o,
  output logic [spqa_pkg::PayW-1:0]     out_payload_o,
  output logic [spqa_pkg::TagW-1:0]     out_tag_o,
  output logic [spqa_pkg::OccW-1:0]     occupancy_o,
  output logic                          is_empty_o,
  output logic                          is_full_o,
  output logic [1:0]                    status_o
);
  import spqa_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t            cell_q [DEPTH];
  entry_t            cell_d [DEPTH];
  logic [CntW-1:0]   cnt_q, cnt_d;
  req_e              req_q;
  entry_t            new_q;
  logic [AmtW-1:0]   amt_q;
  entry_t            res_q, res_d;
  status_e           st_q, st_d;
  logic              empty, full;
  logic [DEPTH-1:0]  occ, gt;

  assign empty = (cnt_q == '0);
  assign full  = (cnt_q == CntW'(DEPTH));
  assign stat_o = '{empty: empty, full: full};

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ[i] = (CntW'(i) < cnt_q);
      gt[i]  = occ[i] && (cell_q[i].prio > new_q.prio);
    end
  end

  always_comb begin
    logic signed [PatW:0] v;
    for (int i = 0; i < DEPTH; i++) cell_d[i] = cell_q[i];
    cnt_d = cnt_q;
    res_d = '0;
    st_d  = ST_OK;
    unique case (req_q)
      REQ_ENQ: begin
        if (full) begin
          st_d = ST_FULL_ERR;
        end else begin
          // cell i keeps, takes the new entry, or shifts up from i-1
          if (gt[0] || !occ[0]) cell_d[0] = new_q;
          for (int i = 1; i < DEPTH; i++) begin
            if (gt[i-1]) begin
              cell_d[i] = cell_q[i-1];
            end else if (gt[i] || (!occ[i] && occ[i-1])) begin
              cell_d[i] = new_q;
            end
          end
          cnt_d = cnt_q + 1'b1;
        end
      end
      REQ_DEQ: begin
        if (empty) begin
          st_d = ST_EMPTY_ERR;
        end else begin
          res_d = cell_q[0];
          for (int i = 0; i < DEPTH - 1; i++) cell_d[i] = cell_q[i+1];
          cnt_d = cnt_q - 1'b1;
        end
      end
      REQ_REDUCE: begin
        for (int i = 0; i < DEPTH; i++) begin
          v = $signed({cell_q[i].patience[PatW-1], cell_q[i].patience})
              - $signed({2'b00, amt_q});
          cell_d[i].patience = (v < -(2**(PatW-1))) ? {1'b1, {(PatW-1){1'b0}}}
                                                    : v[PatW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      st_q  <= ST_OK;
    end else if (cmd_i.exec) begin
      cnt_q <= cnt_d;
      st_q  <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_e'(req_type_i);
      new_q <= '{prio: new_prio_i, patience: new_patience_i,
                 payload: new_payload_i, tag: new_tag_i};
      amt_q <= amount_i;
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
      for (int i = 0; i < DEPTH; i++) cell_q[i] <= cell_d[i];
    end
  end

  assign out_prio_o     = res_q.prio;
  assign out_patience_o = res_q.patience;
  assign out_payload_o  = res_q.payload;
  assign out_tag_o      = res_q.tag;
  assign occupancy_o    = OccW'(cnt_q);
  assign is_empty_o     = empty;
  assign is_full_o      = full;
  assign status_o       = st_q;

endmodule

[hw/rtl/stable_priority_queue_with_aging_core.sv]
// ----------------------------------------------------------------------------
// stable_priority_queue_with_aging_core
// Stable sorted priority queue with patience aging, one result per request.
// ----------------------------------------------------------------------------
// Each request is first captured, then executed in a step in which every
// cell compares, shifts or ages in parallel; the result beat is then held in
// the output registers, and a new request is taken in the cycle it leaves;
// none is taken before the last result has left. Entry contents are not
// cleared by reset; only occupied cells are ever returned as results.
module stable_priority_queue_with_aging_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic [spqa_pkg::PrioW-1:0]    new_prio_i,
  input  logic signed [spqa_pkg::PatW-1:0] new_patience_i,
  input  logic [spqa_pkg::PayW-1:0]     new_payload_i,
  input  logic [spqa_pkg::TagW-1:0]     new_tag_i,
  input  logic [spqa_pkg::AmtW-1:0]     amount_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [spqa_pkg::PrioW-1:0]    out_prio_o,
  output logic signed [spqa_pkg::PatW-1:0] out_patience_o,
  output logic [spqa_pkg::PayW-1:0]     out_payload_o,
  output logic [spqa_pkg::TagW-1:0]     out_tag_o,
  output logic [spqa_pkg::OccW-1:0]     occupancy_o,
  output logic                          is_empty_o,
  output logic                          is_full_o,
  output logic [1:0]                    status_o
);
  import spqa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  spqa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd)
  );

  spqa_dp #(.DEPTH(DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .req_type_i, .new_prio_i, .new_patience_i, .new_payload_i, .new_tag_i,
    .amount_i, .out_prio_o, .out_patience_o, .out_payload_o, .out_tag_o,
    .occupancy_o, .is_empty_o, .is_full_o, .status_o
  );

  a_exec_after_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> cmd.exec) else $error("capture not followed by exec");

  a_result_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |=> out_valid_o) else $error("no result after exec");

  a_not_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.empty && stat.full)) else $error("empty and full together");

endmodule
